@@ design/ang_pkg.sv @@
// ang_pkg: shared types and constants for the audio noise gate
// no dependencies; imported by ang_unit, ang_core and audio_noise_gate

package ang_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned ENERGY_W = 48;
  localparam int unsigned THR_W    = 34;
  localparam int unsigned ATT_W    = 14;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_W    = 34;
  localparam int unsigned ADDR_W   = 2;

  // shared multiplier operand and product widths
  localparam int unsigned OPND_W = 24;
  localparam int unsigned PROD_W = 2 * OPND_W;

  // magnitude product |sample| * attack count fits in this many bits
  localparam int unsigned DIV_STEPS = 29;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // discharge factor 0.9875778 in Q0.24
  localparam logic [OPND_W-1:0] DISCHARGE_Q24 = 24'd16568806;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // register reset values
  localparam logic [THR_W-1:0]  THR_RESET  = 34'd31470000;
  localparam logic [ATT_W-1:0]  ATT_RESET  = 14'd1440;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd4800;

  // gate phases
  localparam logic [PHASE_W-1:0] PHASE_GATE   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_ATTACK = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_HOLD   = 2'd2;

  // configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_HOLD      = 2'd3
  } reg_idx_e;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } unit_op_e;

  typedef struct packed {
    unit_op_e          op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic              enable;
    logic [THR_W-1:0]  threshold;
    logic [ATT_W-1:0]  attack_ticks;
    logic [HOLD_W-1:0] hold_ticks;
  } cfg_t;

endpackage

@@ design/audio_noise_gate.sv @@
// audio_noise_gate: top level with stream ports, configuration registers and output register
// depends on ang_pkg, ang_unit and ang_core

// Noise gate for signed Q1.15 audio samples with a leaky energy detector, an attack ramp
// and a hold time. One sample is processed at a time through a single shared 24x24
// multiplier that also runs a restoring divider one quotient bit per cycle. With gating
// disabled the sample goes straight to the result; the next sample is taken only once
// the result has left the core. In the gate and hold phases, and in attack with zero
// attack_ticks, the energy and phase steps come first. In the attack phase with nonzero
// attack_ticks the result also waits for the scaling multiply and the 29 divide steps.
// The result sits in an output register, so a new sample is taken while it waits.
// Configuration registers: 0 gate_enable, 1 threshold_energy (Q8.40), 2 attack_ticks,
// 3 hold_ticks; write them only while no sample is in flight.

module audio_noise_gate import ang_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] sample_in
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [15:0] sample_out
  output logic [1:0]          m_axis_tuser,   // [1:0] gate_phase
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  cfg_t                cfg_q;
  unit_req_t           req;
  logic [PROD_W-1:0]   prod;
  logic                core_out_valid;
  logic                slot_free;
  logic [SAMPLE_W-1:0] core_sample;
  logic [PHASE_W-1:0]  core_phase;
  logic                m_valid_q;
  logic [SAMPLE_W-1:0] m_data_q;
  logic [PHASE_W-1:0]  m_user_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b0;
      cfg_q.threshold    <= THR_RESET;
      cfg_q.attack_ticks <= ATT_RESET;
      cfg_q.hold_ticks   <= HOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_ENABLE:    cfg_q.enable       <= cfg_wdata_i[0];
        REG_THRESHOLD: cfg_q.threshold    <= cfg_wdata_i[THR_W-1:0];
        REG_ATTACK:    cfg_q.attack_ticks <= cfg_wdata_i[ATT_W-1:0];
        REG_HOLD:      cfg_q.hold_ticks   <= cfg_wdata_i[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ang_unit u_unit (
    .clk_i  (clk_i),
    .req_i  (req),
    .prod_o (prod)
  );

  ang_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .out_valid_o (core_out_valid),
    .out_ready_i (slot_free),
    .sample_o    (core_sample),
    .phase_o     (core_phase),
    .req_o       (req),
    .prod_i      (prod)
  );

  // output register
  assign slot_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= PHASE_GATE;
    end else if (slot_free) begin
      m_valid_q <= core_out_valid;
      if (core_out_valid) begin
        m_data_q <= core_sample;
        m_user_q <= core_phase;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // phase code on the output is always a real phase
  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == PHASE_GATE || m_axis_tuser == PHASE_ATTACK ||
                       m_axis_tuser == PHASE_HOLD))
    else $error("invalid gate phase on output");

  // one sample at a time: input closes right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // a finished result never coexists with an open input
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_out_valid |-> !s_axis_tready)
    else $error("core result pending while input ready");

endmodule

@@ design/ang_unit.sv @@
// ang_unit: shared 24x24 multiplier with a restoring divide step on its product register
// depends on ang_pkg

module ang_unit import ang_pkg::*; (
  input  logic              clk_i,
  input  unit_req_t         req_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;
  logic [ATT_W-1:0]  rem_q;
  logic [ATT_W:0]    trial;
  logic [ATT_W:0]    diff;
  logic              ge;

  // one restoring divide step: next dividend bit sits at the top of the quotient field
  assign trial = {rem_q, prod_q[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, req_i.b[ATT_W-1:0]};
  assign ge    = trial >= {1'b0, req_i.b[ATT_W-1:0]};

  // product / quotient and remainder registers
  always_ff @(posedge clk_i) begin
    unique case (req_i.op)
      OP_MUL: begin
        prod_q <= req_i.a * req_i.b;
        rem_q  <= '0;
      end
      OP_DIV: begin
        prod_q <= {prod_q[PROD_W-2:0], ge};
        rem_q  <= ge ? diff[ATT_W-1:0] : trial[ATT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign prod_o = prod_q;

endmodule

@@ design/ang_core.sv @@
// ang_core: sequencer and gate state; drives the shared unit step by step
// depends on ang_pkg; works with ang_unit

module ang_core import ang_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] sample_o,
  output logic [PHASE_W-1:0]  phase_o,
  output unit_req_t           req_o,
  input  logic [PROD_W-1:0]   prod_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ADD, S_MLO, S_MHI, S_LEAK, S_PHASE, S_SMUL, S_DIV, S_SAT, S_OUT
  } state_e;

  state_e                state_q;
  logic [PHASE_W-1:0]    phase_q;
  logic [ENERGY_W-1:0]   energy_q;
  logic [ENERGY_W-1:0]   sum_q;
  logic [ATT_W-1:0]      att_cnt_q;
  logic [HOLD_W-1:0]     hold_cnt_q;
  logic [SAMPLE_W-1:0]   sample_q;
  logic [SAMPLE_W-1:0]   y_q;
  logic [OPND_W:0]       lo_rnd_q;
  logic [STEP_W-1:0]     step_q;

  logic [SAMPLE_W-1:0]   mag;
  logic [ENERGY_W:0]     sum_full;
  logic [ENERGY_W:0]     leak_full;
  logic [ENERGY_W:0]     rnd_full;
  logic                  loud;
  logic                  loud_ge;
  logic [HOLD_W-1:0]     hold_next;
  logic [DIV_STEPS-1:0]  quot;

  // magnitude of the held sample
  assign mag = sample_q[SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;

  // energy accumulate with the square in Q8.40, then leak
  assign sum_full  = {1'b0, energy_q} + {prod_i[ENERGY_W-11:0], 10'b0};
  assign rnd_full  = {1'b0, prod_i} + (ENERGY_W+1)'(1 << (OPND_W-1));
  assign leak_full = {1'b0, prod_i} + (ENERGY_W+1)'(lo_rnd_q);

  // threshold compares on the updated energy
  assign loud    = energy_q >  ENERGY_W'(cfg_i.threshold);
  assign loud_ge = energy_q >= ENERGY_W'(cfg_i.threshold);

  assign hold_next = loud_ge ? '0 :
                     (hold_cnt_q != {HOLD_W{1'b1}}) ? hold_cnt_q + 1'b1 : hold_cnt_q;

  assign quot = prod_i[DIV_STEPS-1:0];

  // requests to the shared unit
  always_comb begin
    req_o.op = OP_NONE;
    req_o.a  = '0;
    req_o.b  = '0;
    unique case (state_q)
      S_SQ: begin
        req_o.op = OP_MUL;
        req_o.a  = OPND_W'(mag);
        req_o.b  = OPND_W'(mag);
      end
      S_MLO: begin
        req_o.op = OP_MUL;
        req_o.a  = sum_q[OPND_W-1:0];
        req_o.b  = DISCHARGE_Q24;
      end
      S_MHI: begin
        req_o.op = OP_MUL;
        req_o.a  = sum_q[ENERGY_W-1:OPND_W];
        req_o.b  = DISCHARGE_Q24;
      end
      S_SMUL: begin
        req_o.op = OP_MUL;
        req_o.a  = OPND_W'(mag);
        req_o.b  = OPND_W'(att_cnt_q);
      end
      S_DIV: begin
        req_o.op = OP_DIV;
        req_o.b  = OPND_W'(cfg_i.attack_ticks);
      end
      default: begin
      end
    endcase
  end

  // sequencer and gate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PHASE_GATE;
      energy_q   <= '0;
      att_cnt_q  <= '0;
      hold_cnt_q <= '0;
      sum_q      <= '0;
      sample_q   <= '0;
      y_q        <= '0;
      lo_rnd_q   <= '0;
      step_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sample_q <= sample_i;
            if (cfg_i.enable) begin
              state_q <= S_SQ;
            end else begin
              // bypass clears all gate state
              phase_q    <= PHASE_GATE;
              energy_q   <= '0;
              att_cnt_q  <= '0;
              hold_cnt_q <= '0;
              y_q        <= sample_i;
              state_q    <= S_OUT;
            end
          end
        end
        S_SQ: state_q <= S_ADD;
        S_ADD: begin
          sum_q   <= sum_full[ENERGY_W] ? ENERGY_MAX : sum_full[ENERGY_W-1:0];
          state_q <= S_MLO;
        end
        S_MLO: state_q <= S_MHI;
        S_MHI: begin
          // rounded low partial product
          lo_rnd_q <= rnd_full[ENERGY_W:OPND_W];
          state_q  <= S_LEAK;
        end
        S_LEAK: begin
          energy_q <= leak_full[ENERGY_W] ? ENERGY_MAX : leak_full[ENERGY_W-1:0];
          state_q  <= S_PHASE;
        end
        S_PHASE: begin
          state_q <= S_OUT;
          unique case (phase_q)
            PHASE_GATE: begin
              if (loud) begin
                phase_q <= PHASE_ATTACK;
              end
              att_cnt_q <= '0;
              y_q       <= '0;
            end
            PHASE_ATTACK: begin
              if (loud) begin
                if (att_cnt_q < cfg_i.attack_ticks) begin
                  att_cnt_q <= att_cnt_q + 1'b1;
                end else begin
                  phase_q    <= PHASE_HOLD;
                  hold_cnt_q <= '0;
                end
              end else if (att_cnt_q != '0) begin
                att_cnt_q <= att_cnt_q - 1'b1;
              end
              // zero attack ticks passes the sample unscaled
              y_q <= sample_q;
              if (cfg_i.attack_ticks != '0) begin
                state_q <= S_SMUL;
              end
            end
            default: begin
              hold_cnt_q <= hold_next;
              if (hold_next >= cfg_i.hold_ticks) begin
                phase_q <= PHASE_GATE;
              end
              y_q <= sample_q;
            end
          endcase
        end
        S_SMUL: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          // restore sign and clamp to 16-bit range
          if (sample_q[SAMPLE_W-1]) begin
            y_q <= (quot > DIV_STEPS'(32768)) ? 16'h8000 : ~quot[SAMPLE_W-1:0] + 1'b1;
          end else begin
            y_q <= (quot > DIV_STEPS'(32767)) ? 16'h7fff : quot[SAMPLE_W-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign sample_o    = y_q;
  assign phase_o     = phase_q;

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the audio noise gate
// drives sample transactions and config writes, predicts each gated sample and phase
// depends on ang_pkg and audio_noise_gate

module tb_top;
  import ang_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned END_CYCLES  = 64;
  localparam logic [CFG_W-1:0] THR_TOP = 34'd8741000000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [PHASE_W-1:0]  phase;
  } gate_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  reg_idx_e            cfg_addr_i = REG_ENABLE;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;

  audio_noise_gate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // gate model: registers and state
  logic                gate_en      = 1'b0;
  logic [THR_W-1:0]    gate_thr     = THR_RESET;
  logic [ATT_W-1:0]    gate_att     = ATT_RESET;
  logic [HOLD_W-1:0]   gate_hold    = HOLD_RESET;
  logic [PHASE_W-1:0]  gate_phase   = PHASE_GATE;
  logic [ENERGY_W-1:0] gate_energy  = '0;
  logic [ATT_W-1:0]    attack_cnt   = '0;
  logic [HOLD_W-1:0]   quiet_cnt    = '0;

  // bookkeeping
  logic [15:0]         sample_queue[$];
  gate_result_t        gate_expected[$];
  int unsigned         samples_queued = 0;
  int unsigned         samples_accepted = 0;
  int unsigned         results_seen = 0;
  int unsigned         fail_count = 0;
  int unsigned         quiet_cycles = 0;
  bit                  in_taken = 1'b0;
  bit                  sender_smooth = 1'b0;
  bit                  sink_smooth = 1'b0;
  int unsigned         burst_left = 1;
  int unsigned         gap_left = 0;
  logic [31:0]         ready_pat = '0;
  int unsigned         pat_left = 0;

  task automatic report_failure(string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", what);
    end
  endtask

  // one step of the gate: energy detector, phase update, gated sample
  function automatic gate_result_t gate_next(logic [15:0] raw);
    gate_result_t     r;
    logic signed [15:0] s;
    logic [63:0]      sq, sum, hi, lo, lk;
    logic             loud;
    longint           p;
    s = raw;
    r.sample = raw;
    if (gate_en) begin
      sq = longint'(s) * longint'(s);
      sum = {16'd0, gate_energy} + (sq << 10);
      if (sum > ENERGY_MAX) sum = ENERGY_MAX;
      // multiply by the discharge factor, round half up to Q8.40
      hi = sum >> 24;
      lo = sum & 64'hFF_FFFF;
      lk = hi * 64'(DISCHARGE_Q24) + ((lo * 64'(DISCHARGE_Q24) + 64'h80_0000) >> 24);
      gate_energy = (lk > ENERGY_MAX) ? ENERGY_MAX : lk[ENERGY_W-1:0];
      loud = gate_energy > gate_thr;
      case (gate_phase)
        PHASE_GATE: begin
          if (loud) gate_phase = PHASE_ATTACK;
          attack_cnt = '0;
          r.sample = '0;
        end
        PHASE_ATTACK: begin
          if (loud) begin
            if (attack_cnt < gate_att) begin
              attack_cnt = attack_cnt + 1'b1;
            end else begin
              gate_phase = PHASE_HOLD;
              quiet_cnt = '0;
            end
          end else if (attack_cnt != 0) begin
            attack_cnt = attack_cnt - 1'b1;
          end
          // ramp scaling, truncated toward zero and clipped
          if (gate_att != 0) begin
            p = (longint'(s) * longint'(attack_cnt)) / longint'(gate_att);
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            r.sample = 16'(p);
          end
        end
        default: begin
          if (gate_energy >= gate_thr) begin
            quiet_cnt = '0;
          end else if (quiet_cnt != 16'hFFFF) begin
            quiet_cnt = quiet_cnt + 1'b1;
          end
          if (quiet_cnt >= gate_hold) gate_phase = PHASE_GATE;
        end
      endcase
    end else begin
      gate_phase = PHASE_GATE;
      gate_energy = '0;
      attack_cnt = '0;
      quiet_cnt = '0;
    end
    r.phase = gate_phase;
    return r;
  endfunction

  // input side: register writes and predicted result per accepted sample
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ENABLE:    gate_en = cfg_wdata_i[0];
          REG_THRESHOLD: gate_thr = cfg_wdata_i[THR_W-1:0];
          REG_ATTACK:    gate_att = cfg_wdata_i[ATT_W-1:0];
          REG_HOLD:      gate_hold = cfg_wdata_i[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        gate_expected.push_back(gate_next(s_axis_tdata));
        samples_accepted++;
        in_taken = 1'b1;
      end
    end
  end

  // sample driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (gap_left != 0 && !sender_smooth) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_queue.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        end
      end
    end
    in_taken = 1'b0;
  end

  // result sink: ready follows a reloaded bit pattern
  always @(negedge clk_i) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat = $urandom & $urandom;
        1: ready_pat = '1;
        default: ready_pat = $urandom | $urandom;
      endcase
      pat_left = 32;
    end
    m_axis_tready <= sink_smooth || ready_pat[0];
    ready_pat = ready_pat >> 1;
    pat_left--;
  end

  // result check against the oldest prediction, plus activity watch
  always @(posedge clk_i) begin
    gate_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (gate_expected.size() == 0) begin
          report_failure($sformatf("result %0d: unexpected, sample %h phase %0d",
                                   results_seen, m_axis_tdata, m_axis_tuser));
        end else begin
          want = gate_expected.pop_front();
          if (m_axis_tdata !== want.sample || m_axis_tuser !== want.phase) begin
            report_failure($sformatf("result %0d: sample exp %h got %h, phase exp %0d got %0d",
                                     results_seen, want.sample, m_axis_tdata,
                                     want.phase, m_axis_tuser));
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  task automatic queue_sample(logic [15:0] v);
    sample_queue.push_back(v);
    samples_queued++;
  endtask

  // wait until every queued sample has been taken and answered
  task automatic drain_gate();
    while (samples_accepted != samples_queued || gate_expected.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // loud bursts sized to the threshold, quiet tails, some full-scale noise
  task automatic queue_speech(int unsigned count, logic [THR_W-1:0] thr, int unsigned noise_pct);
    int unsigned n_done;
    int unsigned n_loud;
    int unsigned n_quiet;
    int          amp;
    int          q_amp;
    int          v;
    real         level;
    n_done = 0;
    q_amp = $rtoi($sqrt(real'(thr) / 1000.0) / 16.0);
    while (n_done < count) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_sample(16'($urandom));
        n_done++;
      end else begin
        n_loud = $urandom_range(1, 8);
        level = real'(thr) * real'($urandom_range(1, 4)) / (1000.0 * real'(n_loud));
        amp = $rtoi($sqrt(level)) + 1;
        if (amp > 32767) amp = 32767;
        repeat (n_loud) if (n_done < count) begin
          v = amp - int'($urandom_range(0, amp / 8));
          queue_sample(16'(($urandom_range(0, 1) == 1) ? -v : v));
          n_done++;
        end
        n_quiet = $urandom_range(0, 40);
        repeat (n_quiet) if (n_done < count) begin
          v = int'($urandom_range(0, 2 * q_amp)) - q_amp;
          queue_sample(16'(v));
          n_done++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] en_w;
    logic [CFG_W-1:0] thr_w;
    logic [CFG_W-1:0] att_w;
    logic [CFG_W-1:0] hold_w;
    int unsigned      noise_pct;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gating off after reset: samples pass unchanged
    queue_sample(16'h7FFF); queue_sample(16'h8000); queue_sample(16'h0000);
    queue_sample(16'h0001); queue_sample(16'hFFFF);
    drain_gate();

    // zero threshold, zero attack and hold ticks, upper bits masked off
    write_reg(REG_ENABLE, 34'h3_FFFF_FFFF);
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_ATTACK, 34'h3_FFFF_C000);
    write_reg(REG_HOLD, 34'h3_FFFF_0000);
    @(posedge clk_i);
    queue_sample(16'h0000); queue_sample(16'h0001);
    queue_sample(16'h7FFF); queue_sample(16'h8000);
    drain_gate();

    // ramp to a count of five, then shrink attack ticks below it
    write_reg(REG_THRESHOLD, THR_TOP);
    write_reg(REG_ATTACK, 34'd5);
    write_reg(REG_HOLD, 34'd2);
    @(posedge clk_i);
    queue_sample(16'h8000); queue_sample(16'h7FFF); queue_sample(16'h8000);
    queue_sample(16'd12345); queue_sample(16'hFFFF); queue_sample(16'h4000);
    drain_gate();
    write_reg(REG_ATTACK, 34'd2);
    @(posedge clk_i);
    queue_sample(16'h7FFF);
    drain_gate();

    // clear state, then a short loud blip so the attack count falls back to zero
    write_reg(REG_ENABLE, '0);
    @(posedge clk_i);
    queue_sample(16'h1234);
    drain_gate();
    write_reg(REG_ENABLE, 34'd1);
    @(posedge clk_i);
    queue_sample(16'd2960);
    repeat (5) queue_sample(16'h0000);
    drain_gate();

    // random sections, each under its own register setting
    for (int sec = 0; sec < 8; sec++) begin
      drain_gate();
      en_w = 34'd1;
      noise_pct = 3;
      sender_smooth = 1'b0;
      sink_smooth = 1'b0;
      case (sec)
        0: begin
          thr_w = 34'd31470000;
          att_w = 34'd3;
          hold_w = 34'd5;
          sender_smooth = 1'b1;
          sink_smooth = 1'b1;
        end
        1: begin
          thr_w = THR_TOP;
          att_w = CFG_W'($urandom_range(1, 12));
          hold_w = CFG_W'($urandom_range(0, 20));
        end
        2: begin
          en_w = {32'($urandom), 2'b10};
          thr_w = {2'($urandom_range(0, 3)), 32'($urandom)};
          att_w = {2'($urandom_range(0, 3)), 32'($urandom)};
          hold_w = {2'($urandom_range(0, 3)), 32'($urandom)};
          noise_pct = 100;
        end
        3: begin
          thr_w = '0;
          att_w = 34'd14400;
          hold_w = 34'd48000;
        end
        4: begin
          thr_w = '1;
          att_w = {20'($urandom), 14'($urandom_range(1, 8))};
          hold_w = {18'($urandom), 16'($urandom_range(1, 10))};
        end
        5: begin
          thr_w = CFG_W'(64'($urandom_range(10000000, 2000000000)) * 2);
          att_w = 34'd480;
          hold_w = 34'd480;
        end
        6: begin
          thr_w = CFG_W'(64'($urandom_range(1000000, 2000000000)) * $urandom_range(1, 4));
          att_w = CFG_W'($urandom_range(1, 16));
          hold_w = CFG_W'($urandom_range(0, 30));
          noise_pct = 5;
          sink_smooth = 1'b1;
        end
        default: begin
          thr_w = 34'd31470000;
          att_w = '0;
          hold_w = CFG_W'($urandom_range(1, 8));
          noise_pct = 10;
        end
      endcase
      write_reg(REG_THRESHOLD, thr_w);
      write_reg(REG_ATTACK, att_w);
      write_reg(REG_HOLD, hold_w);
      write_reg(REG_ENABLE, en_w);
      @(posedge clk_i);
      queue_speech(56, thr_w[THR_W-1:0], noise_pct);
    end

    drain_gate();
    repeat (END_CYCLES) @(negedge clk_i);
    if (gate_expected.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", gate_expected.size()));
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
